FILE: design/rtcs_pkg.sv
package rtcs_pkg;

	localparam int PIX_W          = 8;
	localparam int FRAME_COUNT_W  = 4;
	localparam int FRAME_PIXELS_W = 15;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;

	localparam int MAX_FRAMES_DEF = 8;
	localparam int MAX_PIXELS_DEF = 16384;
	localparam int MIN_FRAMES     = 3;

	localparam logic [FRAME_COUNT_W-1:0]  FRAME_COUNT_RST  = FRAME_COUNT_W'(3);
	localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RST = FRAME_PIXELS_W'(16384);

	localparam logic REG_FRAME_COUNT  = 1'b0;
	localparam logic REG_FRAME_PIXELS = 1'b1;

	localparam int FIFO_DEPTH = 3;
	localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic emit;
		logic last;
	} ctrl_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             last;
	} out_item_t;

endpackage

FILE: design/rtcs_ram.sv
module rtcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: design/rtcs_seq.sv
module rtcs_seq #(
	parameter int MAX_FRAMES = rtcs_pkg::MAX_FRAMES_DEF,
	parameter int MAX_PIXELS = rtcs_pkg::MAX_PIXELS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          flush,
	input  logic                                          advance,
	input  logic [rtcs_pkg::FRAME_COUNT_W-1:0]            frame_count,
	input  logic [rtcs_pkg::FRAME_PIXELS_W-1:0]           frame_pixels,
	output logic [$clog2(MAX_FRAMES)+$clog2(MAX_PIXELS)-1:0] wr_addr,
	output logic [$clog2(MAX_FRAMES)+$clog2(MAX_PIXELS)-1:0] mid_addr,
	output logic [$clog2(MAX_FRAMES)+$clog2(MAX_PIXELS)-1:0] old_addr,
	output rtcs_pkg::ctrl_t                               ctrl
);

	import rtcs_pkg::*;

	localparam int SW = $clog2(MAX_FRAMES);
	localparam int PW = $clog2(MAX_PIXELS);
	localparam int NW = $clog2(MAX_FRAMES + 1);

	logic [SW-1:0] write_slot_q;
	logic [PW-1:0] pos_q;
	logic [NW-1:0] filled_q;

	logic [NW-1:0] n_eff;
	logic [NW-1:0] old_back;
	logic [NW-1:0] mid_back;
	logic [PW-1:0] last_pos;
	logic [SW-1:0] mid_slot;
	logic [SW-1:0] old_slot;

	function automatic logic [SW-1:0] slot_back(input logic [SW-1:0] ws, input logic [NW-1:0] d);
		logic [SW:0] diff;
		diff = (SW+1)'(ws) - (SW+1)'(d);
		if (diff[SW]) begin
			slot_back = SW'(diff + (SW+1)'(MAX_FRAMES));
		end else begin
			slot_back = SW'(diff);
		end
	endfunction

	always_comb begin
		if (32'(frame_count) < 32'(MIN_FRAMES)) begin
			n_eff = NW'(MIN_FRAMES);
		end else if (32'(frame_count) > 32'(MAX_FRAMES)) begin
			n_eff = NW'(MAX_FRAMES);
		end else begin
			n_eff = NW'(frame_count);
		end
	end

	always_comb begin
		if (frame_pixels == '0) begin
			last_pos = '0;
		end else if (32'(frame_pixels) > 32'(MAX_PIXELS)) begin
			last_pos = PW'(MAX_PIXELS - 1);
		end else begin
			last_pos = PW'(frame_pixels - FRAME_PIXELS_W'(1));
		end
	end

	assign old_back = n_eff - NW'(1);
	assign mid_back = old_back - (n_eff >> 1);
	assign mid_slot = slot_back(write_slot_q, mid_back);
	assign old_slot = slot_back(write_slot_q, old_back);

	assign wr_addr   = {write_slot_q, pos_q};
	assign mid_addr  = {mid_slot, pos_q};
	assign old_addr  = {old_slot, pos_q};
	assign ctrl.emit = (filled_q >= old_back);
	assign ctrl.last = (pos_q == last_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			pos_q        <= '0;
			filled_q     <= '0;
		end else if (flush) begin
			write_slot_q <= '0;
			pos_q        <= '0;
			filled_q     <= '0;
		end else if (advance) begin
			if (ctrl.last) begin
				pos_q <= '0;
				if (write_slot_q == SW'(MAX_FRAMES - 1)) begin
					write_slot_q <= '0;
				end else begin
					write_slot_q <= write_slot_q + SW'(1);
				end
				if (filled_q != NW'(MAX_FRAMES)) begin
					filled_q <= filled_q + NW'(1);
				end
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

endmodule

FILE: design/rtcs_ofifo.sv
module rtcs_ofifo (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  rtcs_pkg::out_item_t            push_item,
	input  logic                           pop,
	output logic [rtcs_pkg::LEVEL_W-1:0]   level,
	output rtcs_pkg::out_item_t            head
);

	import rtcs_pkg::*;

	out_item_t         entry_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;

	function automatic logic [FPTR_W-1:0] ptr_next(input logic [FPTR_W-1:0] p);
		if (p == FPTR_W'(FIFO_DEPTH - 1)) begin
			ptr_next = '0;
		end else begin
			ptr_next = p + FPTR_W'(1);
		end
	endfunction

	assign level = level_q;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + LEVEL_W'(1);
				2'b01:   level_q <= level_q - LEVEL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

FILE: design/rgb_time_channel_split.sv
// Channel    Handshake             Payload
// in         in_valid / in_stall   red, green, blue
// out        out_valid / out_stall out_red, out_green, out_blue, last_pixel
// cfg        APB write/read        frame_count (0x0), frame_pixels (0x4)
//
// One pixel per cycle unless stalled; requests pass read stage and queue to output.
// Rate is set by the frame store: one green and one blue RAM, each one write
// and one read per cycle, so the two history reads never collide.
// Reset clears counters, loads config defaults; frame memory content is not cleared.
// Output is a three-entry queue; input stalls once queue plus read stage reach three.
module rgb_time_channel_split #(
	parameter int MAX_FRAMES = rtcs_pkg::MAX_FRAMES_DEF,
	parameter int MAX_PIXELS = rtcs_pkg::MAX_PIXELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rtcs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [rtcs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [rtcs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rtcs_pkg::PIX_W-1:0]        red,
	input  logic [rtcs_pkg::PIX_W-1:0]        green,
	input  logic [rtcs_pkg::PIX_W-1:0]        blue,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rtcs_pkg::PIX_W-1:0]        out_red,
	output logic [rtcs_pkg::PIX_W-1:0]        out_green,
	output logic [rtcs_pkg::PIX_W-1:0]        out_blue,
	output logic                              last_pixel
);

	import rtcs_pkg::*;

	localparam int SW        = $clog2(MAX_FRAMES);
	localparam int PW        = $clog2(MAX_PIXELS);
	localparam int AW        = SW + PW;
	localparam int MEM_DEPTH = MAX_FRAMES * (2 ** PW);

	logic [FRAME_COUNT_W-1:0]  frame_count_q;
	logic [FRAME_PIXELS_W-1:0] frame_pixels_q;
	logic                      cfg_write;
	logic                      accept;

	logic [AW-1:0] wr_addr;
	logic [AW-1:0] mid_addr;
	logic [AW-1:0] old_addr;
	ctrl_t         ctrl;

	logic             valid_s1;
	ctrl_t            ctrl_s1;
	logic [PIX_W-1:0] red_s1;
	logic [PIX_W-1:0] mid_green;
	logic [PIX_W-1:0] old_blue;

	logic               push;
	out_item_t          push_item;
	out_item_t          head;
	logic [LEVEL_W-1:0] level;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q  <= FRAME_COUNT_RST;
			frame_pixels_q <= FRAME_PIXELS_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_FRAME_COUNT:  frame_count_q  <= pwdata[FRAME_COUNT_W-1:0];
				REG_FRAME_PIXELS: frame_pixels_q <= pwdata[FRAME_PIXELS_W-1:0];
				default:          frame_count_q  <= frame_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_COUNT:  prdata = APB_DATA_W'(frame_count_q);
			REG_FRAME_PIXELS: prdata = APB_DATA_W'(frame_pixels_q);
			default:          prdata = '0;
		endcase
	end

	assign in_stall = ((LEVEL_W+1)'(level) + (LEVEL_W+1)'(valid_s1)) >= (LEVEL_W+1)'(FIFO_DEPTH);
	assign accept   = in_valid && !in_stall;

	rtcs_seq #(
		.MAX_FRAMES(MAX_FRAMES),
		.MAX_PIXELS(MAX_PIXELS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.flush       (cfg_write),
		.advance     (accept),
		.frame_count (frame_count_q),
		.frame_pixels(frame_pixels_q),
		.wr_addr     (wr_addr),
		.mid_addr    (mid_addr),
		.old_addr    (old_addr),
		.ctrl        (ctrl)
	);

	rtcs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MEM_DEPTH)
	) u_green_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(wr_addr),
		.wdata(green),
		.re   (accept),
		.raddr(mid_addr),
		.rdata(mid_green)
	);

	rtcs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MEM_DEPTH)
	) u_blue_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(wr_addr),
		.wdata(blue),
		.re   (accept),
		.raddr(old_addr),
		.rdata(old_blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl;
			red_s1  <= red;
		end
	end

	assign push            = valid_s1 && ctrl_s1.emit;
	assign push_item.red   = red_s1;
	assign push_item.green = mid_green;
	assign push_item.blue  = old_blue;
	assign push_item.last  = ctrl_s1.last;

	rtcs_ofifo u_ofifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (out_valid && !out_stall),
		.level    (level),
		.head     (head)
	);

	assign out_valid  = (level != '0);
	assign out_red    = head.red;
	assign out_green  = head.green;
	assign out_blue   = head.blue;
	assign last_pixel = head.last;

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level != LEVEL_W'(FIFO_DEPTH)))
		else $error("result pushed into full output queue");

	a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request missing from read stage");

	a_history_not_written: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ((mid_addr != wr_addr) && (old_addr != wr_addr)))
		else $error("history read hits the entry being written");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (level == '0)) |=> out_valid)
		else $error("pushed result not presented");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
	import rtcs_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef enum {MODE_RX_HEAVY, MODE_TX_HEAVY, MODE_NONE} idle_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]     paddr = '0;
	logic [APB_DATA_W-1:0]     pwdata = '0;
	logic [APB_DATA_W-1:0]     prdata;
	logic                      pready;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [PIX_W-1:0]          red = '0;
	logic [PIX_W-1:0]          green = '0;
	logic [PIX_W-1:0]          blue = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [PIX_W-1:0]          out_red;
	logic [PIX_W-1:0]          out_green;
	logic [PIX_W-1:0]          out_blue;
	logic                      last_pixel;

	pixel_t      pixel_queue [$];
	out_item_t   expected_pixels [$];
	pixel_t      next_px;
	out_item_t   want_px;
	int unsigned errors = 0;
	int unsigned tx_pct = 0;
	int unsigned rx_pct = 0;

	logic [FRAME_COUNT_W-1:0]  cfg_frames = FRAME_COUNT_RST;
	logic [FRAME_PIXELS_W-1:0] cfg_pixels = FRAME_PIXELS_RST;
	int unsigned ring_slot = 0;
	int unsigned pos_in_frame = 0;
	int unsigned frames_done = 0;
	logic [PIX_W-1:0] hist_green [MAX_FRAMES_DEF][MAX_PIXELS_DEF];
	logic [PIX_W-1:0] hist_blue [MAX_FRAMES_DEF][MAX_PIXELS_DEF];

	rgb_time_channel_split u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.last_pixel (last_pixel)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned span_frames();
		int unsigned n;
		n = cfg_frames;
		if (n < MIN_FRAMES) n = MIN_FRAMES;
		if (n > MAX_FRAMES_DEF) n = MAX_FRAMES_DEF;
		return n;
	endfunction

	function automatic int unsigned span_pixels();
		int unsigned np;
		np = cfg_pixels;
		if (np < 1) np = 1;
		if (np > MAX_PIXELS_DEF) np = MAX_PIXELS_DEF;
		return np;
	endfunction

	function automatic void predict_pixel(pixel_t px);
		int unsigned n;
		int unsigned np;
		int unsigned mid;
		int unsigned old;
		logic        is_last;
		out_item_t   res;
		n = span_frames();
		np = span_pixels();
		if (pos_in_frame >= np) pos_in_frame = 0;
		is_last = (pos_in_frame == np - 1);
		if (frames_done >= n - 1) begin
			mid = (ring_slot + MAX_FRAMES_DEF - (n - 1 - n / 2)) % MAX_FRAMES_DEF;
			old = (ring_slot + MAX_FRAMES_DEF - (n - 1)) % MAX_FRAMES_DEF;
			res.red = px.red;
			res.green = hist_green[mid][pos_in_frame];
			res.blue = hist_blue[old][pos_in_frame];
			res.last = is_last;
			expected_pixels.insert(expected_pixels.size(), res);
		end
		hist_green[ring_slot][pos_in_frame] = px.green;
		hist_blue[ring_slot][pos_in_frame] = px.blue;
		if (is_last) begin
			pos_in_frame = 0;
			ring_slot = (ring_slot + 1) % MAX_FRAMES_DEF;
			if (frames_done < MAX_FRAMES_DEF) frames_done++;
		end else begin
			pos_in_frame++;
		end
	endfunction

	function automatic logic [PIX_W-1:0] rand_level();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pixel_queue.size() != 0 && $urandom_range(99) >= tx_pct) begin
				next_px = pixel_queue.pop_front();
				in_valid <= 1'b1;
				red <= next_px.red;
				green <= next_px.green;
				blue <= next_px.blue;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected pixel: r=%0d g=%0d b=%0d last=%0d",
							out_red, out_green, out_blue, last_pixel);
				end else begin
					want_px = expected_pixels.pop_front();
					if (out_red !== want_px.red || out_green !== want_px.green ||
						out_blue !== want_px.blue || last_pixel !== want_px.last) begin
						errors++;
						if (errors <= 10)
							$display("pixel mismatch: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
								want_px.red, want_px.green, want_px.blue, want_px.last,
								out_red, out_green, out_blue, last_pixel);
					end
				end
			end
			if (in_valid && !in_stall)
				predict_pixel(pixel_t'{red, green, blue});
		end
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			MODE_RX_HEAVY: begin
				tx_pct = 13;
				rx_pct = 75;
			end
			MODE_TX_HEAVY: begin
				tx_pct = 75;
				rx_pct = 13;
			end
			default: begin
				tx_pct = 0;
				rx_pct = 0;
			end
		endcase
	endtask

	task automatic write_reg(logic idx, logic [APB_DATA_W-1:0] value);
		logic [APB_DATA_W-1:0] word;
		word = $urandom();
		if (idx == REG_FRAME_COUNT)
			word[FRAME_COUNT_W-1:0] = value[FRAME_COUNT_W-1:0];
		else
			word[FRAME_PIXELS_W-1:0] = value[FRAME_PIXELS_W-1:0];
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FRAME_COUNT)
			cfg_frames = word[FRAME_COUNT_W-1:0];
		else
			cfg_pixels = word[FRAME_PIXELS_W-1:0];
		ring_slot = 0;
		pos_in_frame = 0;
		frames_done = 0;
	endtask

	task automatic read_check(logic idx);
		logic [APB_DATA_W-1:0] want;
		want = (idx == REG_FRAME_COUNT) ? APB_DATA_W'(cfg_frames) : APB_DATA_W'(cfg_pixels);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			errors++;
			if (errors <= 10)
				$display("register %0d readback: expected %0d, got %0d", idx, want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_random(int unsigned count);
		for (int unsigned k = 0; k < count; k++)
			pixel_queue.insert(pixel_queue.size(),
				pixel_t'{rand_level(), rand_level(), rand_level()});
	endtask

	// hold until every request is taken and every pixel is out, then let the pipe settle
	task automatic drain();
		while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		#(8 * 2_000_000);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [PIX_W-1:0] pattern [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
		int unsigned forced_frames [11] = '{0, 1, 2, 15, 9, 8, 4, 5, 6, 7, 3};
		int unsigned forced_pixels [4] = '{0, 1, 2, 3};
		int unsigned phase_idx;
		int unsigned sel;
		int unsigned n;
		int unsigned np;
		int unsigned items;
		int unsigned random_done;
		phase_idx = 0;
		random_done = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(MODE_RX_HEAVY);
		read_check(REG_FRAME_COUNT);
		read_check(REG_FRAME_PIXELS);

		write_reg(REG_FRAME_COUNT, 3);
		write_reg(REG_FRAME_PIXELS, 5);
		for (int k = 0; k < 20; k++)
			pixel_queue.insert(pixel_queue.size(), pixel_t'{pattern[k % 8],
				pattern[(k + 3) % 8], pattern[(k + 5) % 8]});
		drain();

		while (random_done < 900) begin
			if (random_done >= 600)
				set_idling(MODE_NONE);
			else if (random_done >= 300)
				set_idling(MODE_TX_HEAVY);
			sel = (phase_idx < 11) ? 3 : $urandom_range(3);
			if (sel[0])
				write_reg(REG_FRAME_COUNT,
					(phase_idx < 11) ? forced_frames[phase_idx] : $urandom_range(15));
			if (sel[1])
				write_reg(REG_FRAME_PIXELS,
					(phase_idx < 4) ? forced_pixels[phase_idx] : $urandom_range(24, 1));
			if (sel != 0) begin
				read_check(REG_FRAME_COUNT);
				read_check(REG_FRAME_PIXELS);
			end
			n = span_frames();
			np = span_pixels();
			if ($urandom_range(7) == 0)
				items = $urandom_range(np * (n - 1), 1);
			else
				items = np * (n + $urandom_range(2)) + $urandom_range(np - 1);
			push_random(items);
			random_done += items;
			drain();
			phase_idx++;
		end

		// both registers clamped; no frame completes, so nothing comes out
		write_reg(REG_FRAME_COUNT, 0);
		write_reg(REG_FRAME_PIXELS, 32'h7FFF);
		read_check(REG_FRAME_COUNT);
		read_check(REG_FRAME_PIXELS);
		push_random(32);
		drain();
		repeat (20) @(negedge clk);

		if (errors == 0 && expected_pixels.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
